[rtl/core/efd_pkg.sv]
`default_nettype none

package efd_pkg;

	localparam logic [7:0] MARK  = 8'h55;
	localparam logic [7:0] OPEN  = 8'h01;
	localparam logic [7:0] STUFF = 8'h02;
	localparam logic [7:0] CLOSE = 8'h03;

	localparam int LEN_W = 6;
	localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 6'd63;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_word_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             last_of_frame;
		logic [LEN_W-1:0] payload_length;
	} frame_word_t;

	typedef struct packed {
		logic clear;
		logic store;
		logic store_mark;
		logic latch_len;
		logic rd_en;
	} cmd_t;

	typedef struct packed {
		logic is_mark;
		logic is_open;
		logic is_stuff;
		logic is_close;
		logic full;
		logic empty;
		logic frame_ok;
		logic len_zero;
		logic rd_last;
	} sts_t;

endpackage

`default_nettype wire

[rtl/core/efd_stream_if.sv]
`default_nettype none

interface efd_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/efd_datapath.sv]
`default_nettype none

module efd_datapath #(
	parameter int BUFFER_DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [7:0]                 rx_byte,
	input  wire logic                       cfg_wr_en,
	input  wire logic [efd_pkg::LEN_W-1:0]  cfg_wr_data,
	input  wire efd_pkg::cmd_t              cmd,
	output efd_pkg::sts_t                   sts,
	output efd_pkg::frame_word_t            word
);
	localparam int AW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW    = $clog2(BUFFER_DEPTH + 1);
	localparam int CMP_W = (CW > efd_pkg::LEN_W) ? CW : efd_pkg::LEN_W;

	logic [7:0]                mem [BUFFER_DEPTH];
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             len_q;
	logic [AW-1:0]             idx_q;
	logic [7:0]                sum_q;
	logic [7:0]                last_q;
	logic [efd_pkg::LEN_W-1:0] max_length_q;
	logic [7:0]                wdata;
	logic [CW-1:0]             len_now;
	logic [7:0]                payload_sum;

	assign wdata       = cmd.store_mark ? efd_pkg::MARK : rx_byte;
	assign len_now     = cnt_q - CW'(1);
	assign payload_sum = sum_q - last_q;

	assign sts.is_mark  = (rx_byte == efd_pkg::MARK);
	assign sts.is_open  = (rx_byte == efd_pkg::OPEN);
	assign sts.is_stuff = (rx_byte == efd_pkg::STUFF);
	assign sts.is_close = (rx_byte == efd_pkg::CLOSE);
	assign sts.full     = (cnt_q == CW'(BUFFER_DEPTH));
	assign sts.empty    = (cnt_q == '0);
	assign sts.len_zero = (cnt_q == CW'(1));
	assign sts.frame_ok = (payload_sum == last_q) &&
		(CMP_W'(len_now) <= CMP_W'(max_length_q));
	assign sts.rd_last  = (CW'(idx_q) == len_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			sum_q        <= '0;
			max_length_q <= efd_pkg::MAX_LENGTH_RESET;
		end else begin
			if (cfg_wr_en) begin
				max_length_q <= cfg_wr_data;
			end
			if (cmd.clear) begin
				cnt_q <= '0;
				sum_q <= '0;
			end else if (cmd.store || cmd.store_mark) begin
				cnt_q <= cnt_q + CW'(1);
				sum_q <= sum_q + wdata;
			end
		end
	end

	// frame store and read side
	always_ff @(posedge clk) begin
		if (cmd.store || cmd.store_mark) begin
			mem[cnt_q[AW-1:0]] <= wdata;
			last_q             <= wdata;
		end
		if (cmd.latch_len) begin
			len_q <= len_now;
			idx_q <= '0;
		end else if (cmd.rd_en) begin
			word.data_byte      <= mem[idx_q];
			word.last_of_frame  <= sts.rd_last;
			word.payload_length <= efd_pkg::LEN_W'(len_q);
			idx_q               <= idx_q + AW'(1);
		end
	end

endmodule

`default_nettype wire

[rtl/core/efd_ctrl.sv]
`default_nettype none

module efd_ctrl (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    rx_valid,
	output logic         rx_ready,
	output logic         frame_valid,
	input  wire logic    frame_ready,
	input  wire efd_pkg::sts_t sts,
	output efd_pkg::cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_DATA,
		S_ESC,
		S_START,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   acc;
	logic   slot_free;

	assign rx_ready  = (state_q != S_EMIT);
	assign acc       = rx_valid && rx_ready;
	assign slot_free = !frame_valid || frame_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && sts.is_mark) begin
					state_d = S_START;
				end
			end
			S_DATA: begin
				if (acc) begin
					if (sts.is_mark) begin
						state_d = S_ESC;
					end else if (sts.full) begin
						state_d = S_IDLE;
					end else begin
						cmd.store = 1'b1;
					end
				end
			end
			S_ESC: begin
				if (acc) begin
					if (sts.is_stuff) begin
						if (sts.full) begin
							state_d = S_IDLE;
						end else begin
							cmd.store_mark = 1'b1;
							state_d        = S_DATA;
						end
					end else if (sts.is_close) begin
						state_d = S_IDLE;
						if (!sts.empty) begin
							cmd.latch_len = 1'b1;
							if (sts.frame_ok && !sts.len_zero) begin
								state_d = S_EMIT;
							end
						end
					end else if (sts.is_mark) begin
						state_d = S_START;
					end else if (sts.is_open) begin
						cmd.clear = 1'b1;
						state_d   = S_DATA;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_START: begin
				if (acc) begin
					if (sts.is_open) begin
						cmd.clear = 1'b1;
						state_d   = S_DATA;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.rd_en = 1'b1;
					if (sts.rd_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			frame_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rd_en) begin
				frame_valid <= 1'b1;
			end else if (frame_ready) begin
				frame_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/escaped_frame_deframer_top.sv]
// channel  | direction | word                                   | note
// rx       | in        | rx_byte                                | one raw line byte
// frame    | out       | data_byte, last_of_frame, payload_length | one payload byte
// cfg      | in        | max_length                             | write enable + data
//
// a received byte is taken in every state but the read-back of a frame
// on a good closing marker the payload is read back from the frame store, one
// word per cycle through the store's single read port; rx is held off meanwhile
// frame stalls hold the output register and pause the read-back
// arst_n clears the state machine, count, sum and max_length (back to 63)
`default_nettype none

module escaped_frame_deframer_top #(
	parameter int BUFFER_DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	efd_stream_if.sink                     rx,
	efd_stream_if.source                   frame,
	input  wire logic                      cfg_wr_en,
	input  wire logic [efd_pkg::LEN_W-1:0] cfg_wr_data
);
	efd_pkg::cmd_t        cmd;
	efd_pkg::sts_t        sts;
	efd_pkg::frame_word_t word;
	efd_pkg::rx_word_t    rx_word;

	assign rx_word       = rx.payload;
	assign frame.payload = word;

	efd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx.valid),
		.rx_ready    (rx.ready),
		.frame_valid (frame.valid),
		.frame_ready (frame.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	efd_datapath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_word.rx_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts),
		.word        (word)
	);

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

	localparam int STORE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SINK_HOLD = 300;

	typedef enum logic [1:0] {HUNT, BODY, ESCAPE, OPENING} line_phase_t;

	class deframe_scoreboard;
		line_phase_t           phase;
		logic [7:0]            frame_bytes [STORE_DEPTH];
		logic [6:0]            body_count;
		logic [7:0]            body_sum;
		logic [5:0]            max_len;
		efd_pkg::frame_word_t  payload_due [$];
		int                    errors;
		int                    words_checked;
		int                    frames_out;

		function new();
			phase = HUNT;
			body_count = '0;
			body_sum = '0;
			max_len = efd_pkg::MAX_LENGTH_RESET;
			errors = 0;
			words_checked = 0;
			frames_out = 0;
		endfunction

		function bit store_body(input logic [7:0] b);
			if (body_count >= STORE_DEPTH)
				return 1'b0;
			frame_bytes[body_count[5:0]] = b;
			body_count = body_count + 7'd1;
			body_sum = body_sum + b;
			return 1'b1;
		endfunction

		function void open_check(input logic [7:0] b);
			if (b == efd_pkg::OPEN) begin
				phase = BODY;
				body_sum = '0;
				body_count = '0;
			end else begin
				phase = HUNT;
			end
		endfunction

		// noted on every accepted line byte
		function void deframe_byte(input logic [7:0] b);
			logic [6:0]           len;
			logic [7:0]           chk;
			logic [7:0]           sum;
			efd_pkg::frame_word_t w;
			case (phase)
				HUNT: begin
					if (b == efd_pkg::MARK)
						phase = OPENING;
				end
				BODY: begin
					if (b == efd_pkg::MARK)
						phase = ESCAPE;
					else if (!store_body(b))
						phase = HUNT;
				end
				ESCAPE: begin
					if (b == efd_pkg::STUFF) begin
						phase = BODY;
						if (!store_body(efd_pkg::MARK))
							phase = HUNT;
					end else if (b == efd_pkg::CLOSE) begin
						phase = HUNT;
						if (body_count != 0) begin
							len = body_count - 7'd1;
							chk = frame_bytes[len[5:0]];
							sum = body_sum - chk;
							body_count = len;
							body_sum = sum;
							if (sum == chk && len <= {1'b0, max_len}) begin
								for (int i = 0; i < len; i++) begin
									w.data_byte = frame_bytes[6'(i)];
									w.last_of_frame = (i == len - 1);
									w.payload_length = len[5:0];
									payload_due.push_back(w);
								end
								if (len != 0)
									frames_out++;
							end
						end
					end else if (b == efd_pkg::MARK) begin
						phase = OPENING;
					end else begin
						open_check(b);
					end
				end
				default: open_check(b);
			endcase
		endfunction

		function void check_frame_word(input efd_pkg::frame_word_t got);
			efd_pkg::frame_word_t want;
			if (payload_due.size() == 0) begin
				errors++;
				$display("%0t: word with none due, expected nothing, got data %02h last %0b len %0d",
					$time, got.data_byte, got.last_of_frame, got.payload_length);
				return;
			end
			want = payload_due.pop_front();
			words_checked++;
			if (got.data_byte !== want.data_byte) begin
				errors++;
				$display("%0t: data_byte expected %02h got %02h",
					$time, want.data_byte, got.data_byte);
			end
			if (got.last_of_frame !== want.last_of_frame) begin
				errors++;
				$display("%0t: last_of_frame expected %0b got %0b",
					$time, want.last_of_frame, got.last_of_frame);
			end
			if (got.payload_length !== want.payload_length) begin
				errors++;
				$display("%0t: payload_length expected %0d got %0d",
					$time, want.payload_length, got.payload_length);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [5:0] cfg_wr_data;
	bit         src_steady;
	bit         sink_steady;
	bit         hold_sink;
	int         line_bytes;
	int         frames_sent;
	int         settings_used;
	int         cycles;
	int         sink_wait;
	logic [7:0] opening_bytes [45];

	deframe_scoreboard sb;

	efd_stream_if #(.payload_t(efd_pkg::rx_word_t))    rx_if ();
	efd_stream_if #(.payload_t(efd_pkg::frame_word_t)) frame_if ();

	escaped_frame_deframer_top #(
		.BUFFER_DEPTH(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.frame(frame_if),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (frame_if.valid && frame_if.ready)
				sb.check_frame_word(frame_if.payload);
			if (rx_if.valid && rx_if.ready)
				sb.deframe_byte(rx_if.payload.rx_byte);
		end
	end

	function automatic int pick_gap(input bit steady);
		if (steady)
			return 0;
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(0, 16);
		return $urandom_range(0, 1);
	endfunction

	// frame sink with random stalls and the occasional long hold-off
	initial begin
		frame_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_sink) begin
				sink_wait = SINK_HOLD;
				hold_sink = 1'b0;
			end else begin
				sink_wait = pick_gap(sink_steady);
			end
			if (sink_wait > 0) begin
				frame_if.ready <= 1'b0;
				repeat (sink_wait) @(posedge clk);
			end
			frame_if.ready <= 1'b1;
			do @(posedge clk); while (!frame_if.valid);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap(src_steady);
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.payload <= efd_pkg::rx_word_t'(b);
		do @(posedge clk); while (!rx_if.ready);
		line_bytes++;
	endtask

	task automatic send_body(input logic [7:0] b);
		if (b == efd_pkg::MARK) begin
			send_byte(efd_pkg::MARK);
			send_byte(efd_pkg::STUFF);
		end else begin
			send_byte(b);
		end
	endtask

	function automatic logic [7:0] body_value();
		int r;
		r = $urandom_range(0, 29);
		if (r < 5)
			return efd_pkg::MARK;
		case (r)
			5: return 8'h00;
			6: return 8'hFF;
			7: return efd_pkg::OPEN;
			8: return efd_pkg::STUFF;
			9: return efd_pkg::CLOSE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] bad_escape_value();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == efd_pkg::OPEN || b == efd_pkg::STUFF || b == efd_pkg::CLOSE ||
			b == efd_pkg::MARK);
		return b;
	endfunction

	task automatic send_frame(input int len, input bit good_sum);
		logic [7:0] b;
		logic [7:0] sum;
		sum = '0;
		send_byte(efd_pkg::MARK);
		send_byte(efd_pkg::OPEN);
		for (int i = 0; i < len; i++) begin
			b = body_value();
			sum = sum + b;
			send_body(b);
		end
		if (!good_sum)
			sum = sum + 8'($urandom_range(1, 255));
		send_body(sum);
		send_byte(efd_pkg::MARK);
		send_byte(efd_pkg::CLOSE);
		frames_sent++;
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		if (r < 85)
			return $urandom_range(1, 12);
		if (r < 95)
			return $urandom_range(13, 40);
		if (r < 99)
			return $urandom_range(55, 63);
		return $urandom_range(64, 66);
	endfunction

	task automatic send_random_item();
		int kind;
		kind = $urandom_range(0, 99);
		repeat ($urandom_range(0, 2))
			send_byte($urandom_range(0, 3) == 0 ? efd_pkg::MARK : 8'($urandom_range(0, 255)));
		if (kind < 72) begin
			send_frame(pick_len(), $urandom_range(0, 9) != 0);
		end else if (kind < 82) begin
			// partial frame cut short by a fresh opening marker
			send_byte(efd_pkg::MARK);
			send_byte(efd_pkg::OPEN);
			repeat ($urandom_range(0, 6))
				send_body(body_value());
			if ($urandom_range(0, 1) == 0)
				send_byte(efd_pkg::MARK);
			send_frame(pick_len(), $urandom_range(0, 9) != 0);
		end else if (kind < 90) begin
			send_byte(efd_pkg::MARK);
			send_byte(efd_pkg::OPEN);
			repeat ($urandom_range(0, 6))
				send_body(body_value());
			send_byte(efd_pkg::MARK);
			send_byte(bad_escape_value());
		end else if (kind < 95) begin
			send_byte(efd_pkg::MARK);
			send_byte(efd_pkg::OPEN);
			send_byte(efd_pkg::MARK);
			send_byte(efd_pkg::CLOSE);
		end else begin
			repeat ($urandom_range(3, 8))
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic random_run(input int count);
		int stop_at;
		stop_at = line_bytes + count;
		src_steady = $urandom_range(0, 2) == 0;
		sink_steady = $urandom_range(0, 2) == 0;
		while (line_bytes < stop_at) begin
			if ($urandom_range(0, 15) == 0)
				src_steady = !src_steady;
			if ($urandom_range(0, 15) == 0)
				sink_steady = !sink_steady;
			send_random_item();
		end
	endtask

	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.payload_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [5:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.max_len = v;
		settings_used++;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		rx_if.valid = 1'b0;
		rx_if.payload = '0;
		src_steady = 1'b0;
		sink_steady = 1'b0;
		hold_sink = 1'b0;
		line_bytes = 0;
		frames_sent = 0;
		settings_used = 1;
		opening_bytes = '{
			8'hFF,
			efd_pkg::MARK, efd_pkg::MARK, 8'h00,
			efd_pkg::MARK, efd_pkg::OPEN, 8'hFF, efd_pkg::MARK, efd_pkg::STUFF, 8'h54,
			efd_pkg::MARK, efd_pkg::CLOSE,
			efd_pkg::MARK, efd_pkg::OPEN, 8'h00, efd_pkg::MARK, efd_pkg::CLOSE,
			efd_pkg::MARK, efd_pkg::OPEN, efd_pkg::MARK, efd_pkg::CLOSE,
			efd_pkg::MARK, efd_pkg::OPEN, 8'h07, efd_pkg::MARK, efd_pkg::MARK,
			efd_pkg::OPEN, 8'h00, efd_pkg::MARK, efd_pkg::OPEN, 8'h09, 8'h09,
			efd_pkg::MARK, efd_pkg::CLOSE,
			efd_pkg::MARK, efd_pkg::OPEN, 8'h07, 8'h06, efd_pkg::MARK, efd_pkg::CLOSE,
			efd_pkg::MARK, efd_pkg::OPEN, 8'h07, efd_pkg::MARK, 8'h04
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_bytes[i])
			send_byte(opening_bytes[i]);

		write_max_length(6'd0);
		random_run(40);

		// fill the block while the sink holds off
		write_max_length(6'd63);
		src_steady = 1'b1;
		hold_sink = 1'b1;
		send_frame(63, 1'b1);
		send_frame(20, 1'b1);
		send_frame(64, 1'b1);
		send_frame(2, 1'b1);
		random_run(50);

		write_max_length(6'($urandom_range(1, 62)));
		random_run(45);

		write_max_length(6'd5);
		random_run(35);

		wait_drained();
		$display("%0d line bytes sent in %0d frames, %0d payload words checked in %0d frames",
			line_bytes, frames_sent, sb.words_checked, sb.frames_out);
		$display("%0d max_length settings used, %0d mismatches", settings_used, sb.errors);
		if (sb.errors == 0 && sb.payload_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
